FILE: rtl/fct_pkg.sv
// Shared types and constants for the frustum cull test block.
`timescale 1ns / 1ps

package fct_pkg;

   // Matrix rows are held as 64-bit words of four packed entries
   localparam int CFG_WIDTH = 64;
   localparam int MATRIX_FRAC = 12;
   localparam int COORD_FRAC = 8;

   // Reset rows form the identity matrix (1.0 in Q3.12 on the diagonal)
   localparam logic [CFG_WIDTH-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [CFG_WIDTH-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [CFG_WIDTH-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
   localparam logic [CFG_WIDTH-1:0] ROW_W_RESET = 64'h1000_0000_0000_0000;

   // Command codes of an input word
   typedef enum logic [1:0] {
      CMD_POINT         = 2'd0,
      CMD_BOX_VISIBLE   = 2'd1,
      CMD_BOX_CONTAINED = 2'd2
   } cmd_type;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_ROW_X = 2'd0,
      CSR_ROW_Y = 2'd1,
      CSR_ROW_Z = 2'd2,
      CSR_ROW_W = 2'd3
   } csr_index_type;

   // Load enables of the pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

FILE: rtl/fct_if.sv
// Channel interfaces of the frustum cull test block.
`timescale 1ns / 1ps

// Input word: command plus box corners
interface fct_req_if #(
   parameter int COORD_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic signed [COORD_BITS-1:0] min_x;
   logic signed [COORD_BITS-1:0] min_y;
   logic signed [COORD_BITS-1:0] min_z;
   logic signed [COORD_BITS-1:0] max_x;
   logic signed [COORD_BITS-1:0] max_y;
   logic signed [COORD_BITS-1:0] max_z;

   modport source (
      output valid, command, min_x, min_y, min_z, max_x, max_y, max_z,
      input  ready
   );
   modport sink (
      input  valid, command, min_x, min_y, min_z, max_x, max_y, max_z,
      output ready
   );
endinterface

// Result word: one pass flag
interface fct_rsp_if;
   logic valid;
   logic ready;
   logic passes;

   modport source (output valid, passes, input ready);
   modport sink (input valid, passes, output ready);
endinterface

// Register write channel
interface fct_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/fct_plane_lane.sv
// One clip plane: plane forming, products, vertex select and distance sums.
`timescale 1ns / 1ps

module fct_plane_lane #(
   parameter int COORD_BITS  = 24,
   parameter int MATRIX_BITS = 16,
   parameter bit PLANE_NEG   = 1'b0
) (
   input  logic                         clock,
   input  logic [63:0]                  row_w,
   input  logic [63:0]                  row_r,
   input  logic signed [COORD_BITS-1:0] lo_s1 [3],
   input  logic signed [COORD_BITS-1:0] hi_s1 [3],
   input  fct_pkg::cmd_type             cmd_s2,
   input  fct_pkg::stage_en_type        en,
   output logic                         neg_s4
);
   import fct_pkg::*;

   localparam int PW     = MATRIX_BITS + 1;
   localparam int PROD_W = PW + COORD_BITS;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [PW-1:0]     plane_ff [4];
   logic signed [PW-1:0]     plane_in [4];
   logic signed [PROD_W-1:0] prod_lo_ff [3];
   logic signed [PROD_W-1:0] prod_hi_ff [3];
   logic [2:0]               coef_neg_ff;
   logic signed [PROD_W-1:0] d_s2_ff;
   logic signed [PROD_W-1:0] term_ff [3];
   logic signed [PROD_W-1:0] term_in [3];
   logic signed [PROD_W-1:0] d_s3_ff;
   logic signed [SUM_W-1:0]  sum_a_ff;
   logic signed [SUM_W-1:0]  sum_b_ff;
   logic signed [SUM_W-1:0]  dist_sum;

   // plane = row w plus or minus the chosen row, entry by entry
   always_comb begin
      logic signed [MATRIX_BITS-1:0] w_k;
      logic signed [MATRIX_BITS-1:0] r_k;
      for (int k = 0; k < 4; k++) begin
         w_k = row_w[k*MATRIX_BITS +: MATRIX_BITS];
         r_k = row_r[k*MATRIX_BITS +: MATRIX_BITS];
         if (PLANE_NEG) begin
            plane_in[k] = PW'(w_k) - PW'(r_k);
         end else begin
            plane_in[k] = PW'(w_k) + PW'(r_k);
         end
      end
   end

   // plane coefficients follow the matrix registers
   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
   end

   // stage 2: both products per axis, scaled offset
   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int k = 0; k < 3; k++) begin
            prod_lo_ff[k]  <= PROD_W'(plane_ff[k]) * PROD_W'(lo_s1[k]);
            prod_hi_ff[k]  <= PROD_W'(plane_ff[k]) * PROD_W'(hi_s1[k]);
            coef_neg_ff[k] <= plane_ff[k][PW-1];
         end
         d_s2_ff <= PROD_W'(plane_ff[3]) <<< COORD_FRAC;
      end
   end

   // vertex select per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (cmd_s2)
            CMD_POINT:         term_in[k] = prod_lo_ff[k];
            CMD_BOX_VISIBLE:   term_in[k] = coef_neg_ff[k] ? prod_lo_ff[k] : prod_hi_ff[k];
            CMD_BOX_CONTAINED: term_in[k] = (prod_lo_ff[k] < prod_hi_ff[k]) ?
                                            prod_lo_ff[k] : prod_hi_ff[k];
            default:           term_in[k] = prod_lo_ff[k];
         endcase
      end
   end

   // stage 3: selected terms
   always_ff @(posedge clock) begin
      if (en.s3) begin
         term_ff <= term_in;
         d_s3_ff <= d_s2_ff;
      end
   end

   // stage 4: pair sums
   always_ff @(posedge clock) begin
      if (en.s4) begin
         sum_a_ff <= SUM_W'(d_s3_ff) + SUM_W'(term_ff[0]);
         sum_b_ff <= SUM_W'(term_ff[1]) + SUM_W'(term_ff[2]);
      end
   end

   // final distance, only its sign is needed
   assign dist_sum = sum_a_ff + sum_b_ff;
   assign neg_s4   = dist_sum[SUM_W-1];

endmodule

FILE: rtl/frustum_cull_test_unit.sv
// Top level of the frustum cull test: matrix registers, pipeline control, six plane lanes.
`timescale 1ns / 1ps

//  channel   dir  handshake    word
//  req_bus   in   valid/ready  command, min_x/y/z, max_x/y/z
//  rsp_bus   out  valid/ready  passes
//  csr_bus   in   valid/ready  index, data (one 64-bit matrix row)
//
//  One word per cycle while results are taken; the word is registered in stage 1, its result in stage 5.
//  Stage 2 holds the 36 coordinate-by-coefficient multipliers, which set the depth.
//  Reset clears the stage valid bits and loads the identity matrix.
//  Each stage loads when it is empty or the next stage moves, so bubbles close
//  up under a stalled result and nothing is lost or repeated.
module frustum_cull_test_unit #(
   parameter int COORD_BITS  = 24,
   parameter int MATRIX_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   fct_req_if.sink   req_bus,
   fct_rsp_if.source rsp_bus,
   fct_csr_if.sink   csr_bus
);
   import fct_pkg::*;

   logic [CFG_WIDTH-1:0]         matrix_ff [4];
   stage_en_type                 en;
   logic                         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   cmd_type                      cmd_s1_ff, cmd_s2_ff, cmd_s3_ff, cmd_s4_ff;
   logic signed [COORD_BITS-1:0] lo_s1_ff [3];
   logic signed [COORD_BITS-1:0] hi_s1_ff [3];
   logic [5:0]                   plane_neg;
   logic                         passes_ff;
   logic                         passes_in;

   // configuration writes, always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[CSR_ROW_X] <= ROW_X_RESET;
         matrix_ff[CSR_ROW_Y] <= ROW_Y_RESET;
         matrix_ff[CSR_ROW_Z] <= ROW_Z_RESET;
         matrix_ff[CSR_ROW_W] <= ROW_W_RESET;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ROW_X: matrix_ff[CSR_ROW_X] <= csr_bus.data;
            CSR_ROW_Y: matrix_ff[CSR_ROW_Y] <= csr_bus.data;
            CSR_ROW_Z: matrix_ff[CSR_ROW_Z] <= csr_bus.data;
            CSR_ROW_W: matrix_ff[CSR_ROW_W] <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // stage load enables, back from the output register
   assign en.s5 = !v5_ff || rsp_bus.ready;
   assign en.s4 = !v4_ff || en.s5;
   assign en.s3 = !v3_ff || en.s4;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_bus.ready = en.s1 && !reset;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_bus.valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
         if (en.s5) v5_ff <= v4_ff;
      end
   end

   // stage 1: input word; command rides along to the end
   always_ff @(posedge clock) begin
      if (en.s1) begin
         cmd_s1_ff   <= cmd_type'(req_bus.command);
         lo_s1_ff[0] <= req_bus.min_x;
         lo_s1_ff[1] <= req_bus.min_y;
         lo_s1_ff[2] <= req_bus.min_z;
         hi_s1_ff[0] <= req_bus.max_x;
         hi_s1_ff[1] <= req_bus.max_y;
         hi_s1_ff[2] <= req_bus.max_z;
      end
      if (en.s2) cmd_s2_ff <= cmd_s1_ff;
      if (en.s3) cmd_s3_ff <= cmd_s2_ff;
      if (en.s4) cmd_s4_ff <= cmd_s3_ff;
   end

   // six planes: w+x, w-x, w+y, w-y, w+z, w-z
   for (genvar p = 0; p < 6; p++) begin : g_plane
      fct_plane_lane #(
         .COORD_BITS  (COORD_BITS),
         .MATRIX_BITS (MATRIX_BITS),
         .PLANE_NEG   (p % 2 == 1)
      ) u_lane (
         .clock  (clock),
         .row_w  (matrix_ff[CSR_ROW_W]),
         .row_r  (matrix_ff[p >> 1]),
         .lo_s1  (lo_s1_ff),
         .hi_s1  (hi_s1_ff),
         .cmd_s2 (cmd_s2_ff),
         .en     (en),
         .neg_s4 (plane_neg[p])
      );
   end

   // stage 5: result register; the unused command always fails
   assign passes_in = (cmd_s4_ff inside {CMD_POINT, CMD_BOX_VISIBLE, CMD_BOX_CONTAINED})
                      && !(|plane_neg);

   always_ff @(posedge clock) begin
      if (en.s5) begin
         passes_ff <= passes_in;
      end
   end

   assign rsp_bus.valid  = v5_ff;
   assign rsp_bus.passes = passes_ff;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the frustum cull test unit: streamed boxes checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import fct_pkg::*;

   localparam int COORD_BITS  = 24;
   localparam int MATRIX_BITS = 16;
   localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT    = 34;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 16;
   localparam int PHASE_WORDS = 105;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
   } box_word_type;

   typedef enum int {
      STYLE_NEAR,
      STYLE_RANDOM,
      STYLE_EXTREME,
      STYLE_SHARED_ROW
   } matrix_style_type;

   logic clock;
   logic reset;

   fct_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   fct_rsp_if rsp_bus ();
   fct_csr_if csr_bus ();

   frustum_cull_test_unit #(
      .COORD_BITS (COORD_BITS),
      .MATRIX_BITS(MATRIX_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Matrix rows as the block should hold them
   logic [63:0] mat_row [4] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET, ROW_W_RESET};

   box_word_type pending_boxes [$];
   logic         expected_passes [$];

   logic req_fire = 1'b0;
   logic calm = 1'b0;
   logic hold_req = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;
   int   result_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Six planes from row w +/- rows x, y, z; pass when no distance is negative
   function automatic logic cull_passes(input box_word_type b);
      longint signed lo [3];
      longint signed hi [3];
      longint signed plane [4];
      longint signed ew, er, p, q, dist_acc;
      logic [63:0] side;
      logic ok;
      if (b.command != CMD_POINT && b.command != CMD_BOX_VISIBLE &&
          b.command != CMD_BOX_CONTAINED)
         return 1'b0;
      lo[0] = b.min_x;
      lo[1] = b.min_y;
      lo[2] = b.min_z;
      hi[0] = b.max_x;
      hi[1] = b.max_y;
      hi[2] = b.max_z;
      ok = 1'b1;
      for (int pl = 0; pl < 6; pl++) begin
         side = mat_row[pl / 2];
         for (int k = 0; k < 4; k++) begin
            ew = $signed(mat_row[CSR_ROW_W][k*MATRIX_BITS +: MATRIX_BITS]);
            er = $signed(side[k*MATRIX_BITS +: MATRIX_BITS]);
            plane[k] = (pl % 2 == 1) ? ew - er : ew + er;
         end
         // offset brought to the coordinate scale
         dist_acc = plane[3] * longint'(1 << COORD_FRAC);
         for (int k = 0; k < 3; k++) begin
            p = plane[k] * lo[k];
            q = plane[k] * hi[k];
            case (b.command)
               CMD_POINT:       dist_acc += p;
               CMD_BOX_VISIBLE: dist_acc += (plane[k] < 0) ? p : q;
               default:         dist_acc += (p < q) ? p : q;
            endcase
         end
         if (dist_acc < 0) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [63:0] make_row(input matrix_style_type style, input int row_no);
      logic [63:0] r;
      logic [15:0] e;
      for (int c = 0; c < 4; c++) begin
         case (style)
            STYLE_RANDOM: e = 16'($urandom);
            STYLE_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       e = 16'h0000;
                  1:       e = 16'h7FFF;
                  2:       e = 16'h8000;
                  3:       e = 16'hFFFF;
                  default: e = 16'h1000;
               endcase
            end
            default: begin
               // strong diagonal, small cross terms
               if (c == row_no) e = 16'($urandom_range(1024, 12288));
               else e = 16'($urandom_range(0, 4096)) - 16'd2048;
            end
         endcase
         r[c*16 +: 16] = e;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] make_coord();
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         v = $urandom_range(0, 1536);
         v = v - 768;
      end else if (pick < 80) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 5))
            0:       v = COORD_MIN;
            1:       v = COORD_MAX;
            2:       v = 0;
            3:       v = -1;
            4:       v = 256;
            default: v = -256;
         endcase
      end
      return v[COORD_BITS-1:0];
   endfunction

   function automatic box_word_type make_box();
      box_word_type b;
      logic signed [COORD_BITS-1:0] lo [3];
      logic signed [COORD_BITS-1:0] hi [3];
      logic signed [COORD_BITS-1:0] t;
      if ($urandom_range(0, 99) < 4) b.command = CMD_UNUSED;
      else b.command = cmd_type'($urandom_range(CMD_POINT, CMD_BOX_CONTAINED));
      for (int k = 0; k < 3; k++) begin
         lo[k] = make_coord();
         hi[k] = make_coord();
         // mostly ordered boxes, some inverted
         if ($urandom_range(0, 99) < 75 && lo[k] > hi[k]) begin
            t = lo[k];
            lo[k] = hi[k];
            hi[k] = t;
         end
      end
      b.min_x = lo[0];
      b.min_y = lo[1];
      b.min_z = lo[2];
      b.max_x = hi[0];
      b.max_y = hi[1];
      b.max_z = hi[2];
      return b;
   endfunction

   task automatic queue_box(input logic [1:0] cmd, input int x0, input int y0, input int z0,
                            input int x1, input int y1, input int z1);
      box_word_type b;
      b.command = cmd;
      b.min_x = x0[COORD_BITS-1:0];
      b.min_y = y0[COORD_BITS-1:0];
      b.min_z = z0[COORD_BITS-1:0];
      b.max_x = x1[COORD_BITS-1:0];
      b.max_y = y1[COORD_BITS-1:0];
      b.max_z = z1[COORD_BITS-1:0];
      pending_boxes.push_back(b);
   endtask

   task automatic write_matrix_row(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      mat_row[idx] = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_boxes.size() != 0 || expected_passes.size() != 0) @(negedge clock);
   endtask

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // Request driver: hold a word until taken, otherwise offer the next one or idle
   always @(negedge clock) begin
      if (!req_bus.valid || req_fire) begin
         if (pending_boxes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_bus.valid   <= 1'b1;
            req_bus.command <= pending_boxes[0].command;
            req_bus.min_x   <= pending_boxes[0].min_x;
            req_bus.min_y   <= pending_boxes[0].min_y;
            req_bus.min_z   <= pending_boxes[0].min_z;
            req_bus.max_x   <= pending_boxes[0].max_x;
            req_bus.max_y   <= pending_boxes[0].max_y;
            req_bus.max_z   <= pending_boxes[0].max_z;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: predict on each taken word, check each delivered result
   always @(posedge clock) begin : bus_watch
      box_word_type seen;
      logic         want;
      logic         moved;
      moved = 1'b0;
      req_fire = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.command = req_bus.command;
            seen.min_x = req_bus.min_x;
            seen.min_y = req_bus.min_y;
            seen.min_z = req_bus.min_z;
            seen.max_x = req_bus.max_x;
            seen.max_y = req_bus.max_y;
            seen.max_z = req_bus.max_z;
            expected_passes.push_back(cull_passes(seen));
            if (pending_boxes.size() > 0) pending_boxes.pop_front();
            req_fire = 1'b1;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (expected_passes.size() == 0) begin
               report_error($sformatf("unexpected result word, passes=%b", rsp_bus.passes));
            end else begin
               want = expected_passes.pop_front();
               if (rsp_bus.passes !== want)
                  report_error($sformatf("result %0d: passes expected %b, got %b",
                                         result_count, want, rsp_bus.passes));
            end
            result_count++;
         end
         if (csr_bus.valid && csr_bus.ready) moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Watchdog on a stretch with no handshake at all
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Stimulus sequence
   initial begin
      logic [63:0]      rows [4];
      matrix_style_type style;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_POINT;
      req_bus.min_x   = '0;
      req_bus.min_y   = '0;
      req_bus.min_z   = '0;
      req_bus.max_x   = '0;
      req_bus.max_y   = '0;
      req_bus.max_z   = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_ROW_X;
      csr_bus.data    = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity matrix: unit cube in Q15.8 is inside
      queue_box(CMD_POINT, 0, 0, 0, 0, 0, 0);
      queue_box(CMD_POINT, 256, 256, 256, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_box(CMD_POINT, 257, 0, 0, 0, 0, 0);
      queue_box(CMD_POINT, -256, -256, -256, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_box(CMD_POINT, 0, -257, 0, 0, 0, 0);
      queue_box(CMD_POINT, 0, 0, 300, 0, 0, 0);
      queue_box(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_box(CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_box(CMD_BOX_VISIBLE, -1000, -1000, -1000, 1000, 1000, 1000);
      queue_box(CMD_BOX_VISIBLE, 300, 0, 0, 400, 0, 0);
      queue_box(CMD_BOX_VISIBLE, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX);
      queue_box(CMD_BOX_VISIBLE, 100, 100, 100, -100, -100, -100);
      queue_box(CMD_BOX_VISIBLE, 0, 0, 0, 0, 0, 0);
      queue_box(CMD_BOX_CONTAINED, -100, -100, -100, 100, 100, 100);
      queue_box(CMD_BOX_CONTAINED, -100, -100, -100, 300, 100, 100);
      queue_box(CMD_BOX_CONTAINED, 100, 100, 100, -100, -100, -100);
      queue_box(CMD_BOX_CONTAINED, 300, 100, 100, -100, -100, -100);
      queue_box(CMD_BOX_CONTAINED, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX);
      queue_box(CMD_UNUSED, 0, 0, 0, 0, 0, 0);
      queue_box(CMD_UNUSED, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_drained();

      // all-zero matrix: every plane has a zero normal and zero offset
      write_matrix_row(CSR_ROW_X, 64'h0);
      write_matrix_row(CSR_ROW_Y, 64'h0);
      write_matrix_row(CSR_ROW_Z, 64'h0);
      write_matrix_row(CSR_ROW_W, 64'h0);
      queue_box(CMD_BOX_CONTAINED, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX);
      queue_box(CMD_POINT, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0);
      queue_box(CMD_BOX_VISIBLE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                COORD_MIN);
      wait_drained();

      // extreme entries: w - x planes reach the most negative sums
      write_matrix_row(CSR_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
      write_matrix_row(CSR_ROW_Y, 64'h7FFF_7FFF_7FFF_7FFF);
      write_matrix_row(CSR_ROW_Z, 64'h7FFF_7FFF_7FFF_7FFF);
      write_matrix_row(CSR_ROW_W, 64'h8000_8000_8000_8000);
      queue_box(CMD_POINT, 0, 0, 0, 0, 0, 0);
      queue_box(CMD_BOX_VISIBLE, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX);
      wait_drained();

      // random phases, each with a fresh matrix
      for (int ph = 0; ph < PHASES; ph++) begin
         style = matrix_style_type'(ph % 4);
         calm = (ph == 6);
         for (int r = 0; r < 4; r++) rows[r] = make_row(style, r);
         // a shared row gives one plane a zero normal
         if (style == STYLE_SHARED_ROW) rows[$urandom_range(0, 2)] = rows[CSR_ROW_W];
         for (int r = 0; r < 4; r++) write_matrix_row(csr_index_type'(r), rows[r]);
         if (ph == 9) begin
            @(posedge clock);
            hold_req = 1'b1;
         end
         repeat (PHASE_WORDS) pending_boxes.push_back(make_box());
         wait_drained();
      end
      calm = 1'b0;

      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0 && expected_passes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: frustum_cull_test_unit.f
rtl/fct_pkg.sv
rtl/fct_if.sv
rtl/fct_plane_lane.sv
rtl/frustum_cull_test_unit.sv
verif/tb_top.sv
